[src/bitpk_pkg.sv]
// Shared constants, codes and control structs of the ten-bit word bit packer.
// Used by bitpk_ctrl, bitpk_datapath and the top level; depends on nothing.
package bitpk_pkg;

	localparam int STORE_WORDS = 64;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int WORD_BITS   = 10;
	localparam int CNT_W       = 7;
	localparam int DATA_W      = 32;
	localparam int SPAN_WORDS  = 5;
	localparam int SPAN_BITS   = SPAN_WORDS * WORD_BITS;

	localparam logic [2:0] ACT_CLEAR     = 3'd0;
	localparam logic [2:0] ACT_WRITE     = 3'd1;
	localparam logic [2:0] ACT_READ_BITS = 3'd2;
	localparam logic [2:0] ACT_REWIND    = 3'd3;
	localparam logic [2:0] ACT_APPEND    = 3'd4;
	localparam logic [2:0] ACT_READ_WORD = 3'd5;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_OVERRUN  = 2'd1;
	localparam logic [1:0] ERR_BIT_SET  = 2'd2;
	localparam logic [1:0] ERR_REWIND   = 2'd3;

	localparam logic [1:0] RD_SEL_SPAN  = 2'd0;
	localparam logic [1:0] RD_SEL_TRIM  = 2'd1;
	localparam logic [1:0] RD_SEL_INDEX = 2'd2;

	localparam logic [1:0] WR_SEL_SPAN   = 2'd0;
	localparam logic [1:0] WR_SEL_TRIM   = 2'd1;
	localparam logic [1:0] WR_SEL_APPEND = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic [2:0] k;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       collect;
		logic       range_clr;
		logic       err_en;
		logic [1:0] err_code;
		logic       commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] act;
		logic       span_live;
		logic       span_over;
		logic       span_hit;
		logic       rew_err;
		logic       trim_read;
		logic       append_full;
		logic       index_over;
		logic       rsp_free;
	} status_t;

endpackage

[src/bitpk_ctrl.sv]
// Sequencing state machine of the ten-bit word bit packer.
// Depends on bitpk_pkg; drives the datapath through bitpk_pkg::cmd_t.
module bitpk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bitpk_pkg::status_t st,
	output bitpk_pkg::cmd_t   cmd
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_DISPATCH  = 4'd1;
	localparam logic [3:0] ST_SPAN_RD   = 4'd2;
	localparam logic [3:0] ST_SPAN_CHK  = 4'd3;
	localparam logic [3:0] ST_SPAN_PUT  = 4'd4;
	localparam logic [3:0] ST_TRIM      = 4'd5;
	localparam logic [3:0] ST_WORD_GET  = 4'd6;
	localparam logic [3:0] ST_FINISH    = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [2:0] k_q;
	logic       k_inc;
	logic       k_clr;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		k_inc   = 1'b0;
		k_clr   = 1'b0;
		cmd     = '0;
		cmd.k   = k_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					k_clr    = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (st.act)
					bitpk_pkg::ACT_WRITE,
					bitpk_pkg::ACT_READ_BITS: begin
						state_d = ST_SPAN_RD;
					end
					bitpk_pkg::ACT_REWIND: begin
						if (st.rew_err) begin
							cmd.err_en   = 1'b1;
							cmd.err_code = bitpk_pkg::ERR_REWIND;
							state_d      = ST_FINISH;
						end else begin
							cmd.range_clr = 1'b1;
							if (st.trim_read) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = bitpk_pkg::RD_SEL_TRIM;
								state_d    = ST_TRIM;
							end else begin
								state_d = ST_FINISH;
							end
						end
					end
					bitpk_pkg::ACT_APPEND: begin
						if (st.append_full) begin
							cmd.err_en   = 1'b1;
							cmd.err_code = bitpk_pkg::ERR_OVERRUN;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = bitpk_pkg::WR_SEL_APPEND;
						end
						state_d = ST_FINISH;
					end
					bitpk_pkg::ACT_READ_WORD: begin
						if (st.index_over) begin
							cmd.err_en   = 1'b1;
							cmd.err_code = bitpk_pkg::ERR_OVERRUN;
							state_d      = ST_FINISH;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = bitpk_pkg::RD_SEL_INDEX;
							state_d    = ST_WORD_GET;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_SPAN_RD: begin
				if (!st.span_live) begin
					if (st.act == bitpk_pkg::ACT_WRITE) begin
						k_clr   = 1'b1;
						state_d = ST_SPAN_PUT;
					end else begin
						state_d = ST_FINISH;
					end
				end else if (st.span_over) begin
					cmd.err_en   = 1'b1;
					cmd.err_code = bitpk_pkg::ERR_OVERRUN;
					state_d      = ST_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bitpk_pkg::RD_SEL_SPAN;
					state_d    = ST_SPAN_CHK;
				end
			end
			ST_SPAN_CHK: begin
				cmd.collect = 1'b1;
				if (st.act == bitpk_pkg::ACT_WRITE && st.span_hit) begin
					cmd.err_en   = 1'b1;
					cmd.err_code = bitpk_pkg::ERR_BIT_SET;
					state_d      = ST_FINISH;
				end else begin
					k_inc   = 1'b1;
					state_d = ST_SPAN_RD;
				end
			end
			ST_SPAN_PUT: begin
				if (!st.span_live) begin
					state_d = ST_FINISH;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = bitpk_pkg::WR_SEL_SPAN;
					k_inc      = 1'b1;
				end
			end
			ST_TRIM: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = bitpk_pkg::WR_SEL_TRIM;
				state_d    = ST_FINISH;
			end
			ST_WORD_GET: begin
				cmd.collect = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (st.rsp_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (k_clr) begin
				k_q <= '0;
			end else if (k_inc) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

endmodule

[src/bitpk_datapath.sv]
// Datapath of the ten-bit word bit packer: item registers, cursor, word store
// with valid bits, span buffer and result register. Depends on bitpk_pkg.
module bitpk_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [2:0]                       action,
	input  logic [bitpk_pkg::DATA_W-1:0]     bit_data,
	input  logic [5:0]                       bit_count,
	input  logic [9:0]                       bit_position,
	input  logic [bitpk_pkg::WORD_BITS-1:0]  word_value,
	input  logic [5:0]                       word_index,
	input  logic                             rsp_stall,
	input  bitpk_pkg::cmd_t                  cmd,
	output bitpk_pkg::status_t               st,
	output logic                             rsp_valid,
	output logic [bitpk_pkg::DATA_W-1:0]     read_data,
	output logic [bitpk_pkg::CNT_W-1:0]      used_words,
	output logic [1:0]                       error_code
);

	localparam int WB = bitpk_pkg::WORD_BITS;
	localparam int SB = bitpk_pkg::SPAN_BITS;
	localparam int DW = bitpk_pkg::DATA_W;
	localparam int CW = bitpk_pkg::CNT_W;
	localparam int AW = bitpk_pkg::ADDR_W;
	localparam int NW = bitpk_pkg::STORE_WORDS;
	localparam logic [CW-1:0] STORE_END = CW'(bitpk_pkg::STORE_WORDS);

	typedef struct packed {
		logic [2:0] q;
		logic [3:0] r;
	} dm10_t;

	// Splits a cursor offset of at most 41 bits into whole words and bits.
	function automatic dm10_t split_ten(input logic [5:0] s);
		dm10_t res;
		if (s >= 6'd40) begin
			res.q = 3'd4;
			res.r = 4'(s - 6'd40);
		end else if (s >= 6'd30) begin
			res.q = 3'd3;
			res.r = 4'(s - 6'd30);
		end else if (s >= 6'd20) begin
			res.q = 3'd2;
			res.r = 4'(s - 6'd20);
		end else if (s >= 6'd10) begin
			res.q = 3'd1;
			res.r = 4'(s - 6'd10);
		end else begin
			res.q = 3'd0;
			res.r = s[3:0];
		end
		return res;
	endfunction

	// Word k of a span vector; word 0 sits at the top.
	function automatic logic [WB-1:0] span_slot(input logic [SB-1:0] v, input logic [2:0] k);
		logic [WB-1:0] res;
		case (k)
			3'd0:    res = v[SB-1 -: WB];
			3'd1:    res = v[SB-1-WB -: WB];
			3'd2:    res = v[SB-1-2*WB -: WB];
			3'd3:    res = v[SB-1-3*WB -: WB];
			3'd4:    res = v[SB-1-4*WB -: WB];
			default: res = '0;
		endcase
		return res;
	endfunction

	// Item registers.
	logic [2:0]    act_q;
	logic [1:0]    err_q;
	logic [5:0]    n_q;
	logic [SB-1:0] wdat_q;
	logic [SB-1:0] wmsk_q;
	logic [9:0]    pos_q;
	logic [CW-1:0] tw_q;
	logic          rew_err_q;
	logic [WB-1:0] wval_q;
	logic [5:0]    widx_q;

	// Architectural state.
	logic [CW-1:0] wc_q;
	logic [3:0]    bc_q;
	logic [CW-1:0] total_q;
	logic [WB-1:0] mem_q [NW];
	logic [NW-1:0] valid_q;

	logic [WB-1:0] rd_data_q;
	logic          rd_vld_q;
	logic [SB-1:0] coll_q;

	logic          rsp_valid_q;
	logic [DW-1:0] rdat_q;
	logic [CW-1:0] used_q;
	logic [1:0]    code_q;

	// Load-time values.
	logic [5:0]    n_in;
	logic [DW-1:0] la_dat;
	logic [DW-1:0] la_msk;
	logic [10:0]   glob;
	logic [17:0]   pos_prod;

	always_comb begin
		n_in     = (bit_count > 6'd32) ? 6'd32 : bit_count;
		la_dat   = bit_data << (6'd32 - n_in);
		la_msk   = ~({DW{1'b1}} >> n_in);
		glob     = 11'({wc_q, 3'b000}) + 11'({wc_q, 1'b0}) + 11'(bc_q);
		pos_prod = 18'(bit_position) * 18'd205;
	end

	// Working values.
	logic [9:0]    tb_full;
	logic [3:0]    tb;
	logic [CW-1:0] span_addr;
	logic [WB-1:0] w_slot;
	logic [WB-1:0] m_slot;
	logic [WB-1:0] c_slot;
	logic [WB-1:0] rd_eff;
	logic          rsp_free;
	logic [CW-1:0] rd_addr_full;
	logic [CW-1:0] wr_addr_full;
	logic [WB-1:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [NW-1:0] clr_vec;

	always_comb begin
		tb_full   = pos_q - ({tw_q, 3'b000} + {tw_q, 1'b0});
		tb        = tb_full[3:0];
		span_addr = wc_q + {{(CW-3){1'b0}}, cmd.k};
		w_slot    = span_slot(wdat_q, cmd.k);
		m_slot    = span_slot(wmsk_q, cmd.k);
		c_slot    = span_slot(coll_q, cmd.k);
		rd_eff    = rd_vld_q ? rd_data_q : '0;
		rsp_free  = !rsp_valid_q || !rsp_stall;

		case (cmd.rd_sel)
			bitpk_pkg::RD_SEL_TRIM:  rd_addr_full = tw_q;
			bitpk_pkg::RD_SEL_INDEX: rd_addr_full = {1'b0, widx_q};
			default:                 rd_addr_full = span_addr;
		endcase

		case (cmd.wr_sel)
			bitpk_pkg::WR_SEL_TRIM: begin
				wr_addr_full = tw_q;
				wr_data      = rd_eff & ~({WB{1'b1}} >> tb);
			end
			bitpk_pkg::WR_SEL_APPEND: begin
				wr_addr_full = total_q;
				wr_data      = wval_q;
			end
			default: begin
				wr_addr_full = span_addr;
				wr_data      = c_slot | w_slot;
			end
		endcase

		rd_addr = rd_addr_full[AW-1:0];
		wr_addr = wr_addr_full[AW-1:0];
	end

	// Words wiped by a rewind: those after the target word up to the old
	// cursor, and the target word itself when the target is a word boundary.
	always_comb begin
		for (int i = 0; i < NW; i++) begin
			clr_vec[i] = (CW'(i) > tw_q && (CW'(i) < wc_q || (CW'(i) == wc_q && bc_q != 4'd0)))
				|| (CW'(i) == tw_q && tb == 4'd0);
		end
	end

	always_comb begin
		st.act         = act_q;
		st.span_live   = (m_slot != '0);
		st.span_over   = (span_addr >= STORE_END);
		st.span_hit    = ((rd_eff & m_slot) != '0);
		st.rew_err     = rew_err_q;
		st.trim_read   = (tw_q < STORE_END) && (tb != 4'd0);
		st.append_full = (total_q >= STORE_END);
		st.index_over  = ({1'b0, widx_q} >= STORE_END);
		st.rsp_free    = rsp_free;
	end

	// Results of the finishing step.
	dm10_t         split;
	logic [CW-1:0] nwc;
	logic          ok;
	logic [SB-1:0] r_bits;
	logic [SB-1:0] r_shift;
	logic [DW-1:0] r_la;
	logic [DW-1:0] r_out;
	logic [CW-1:0] wc_n;
	logic [3:0]    bc_n;
	logic [CW-1:0] tot_n;
	logic [DW-1:0] rdat_n;

	always_comb begin
		split   = split_ten({2'b00, bc_q} + n_q);
		nwc     = wc_q + {{(CW-3){1'b0}}, split.q};
		ok      = (err_q == bitpk_pkg::ERR_OK);
		r_bits  = coll_q & wmsk_q;
		r_shift = r_bits << bc_q;
		r_la    = r_shift[SB-1 -: DW];
		r_out   = r_la >> (6'd32 - n_q);

		wc_n   = wc_q;
		bc_n   = bc_q;
		tot_n  = total_q;
		rdat_n = '0;
		case (act_q)
			bitpk_pkg::ACT_CLEAR: begin
				wc_n  = '0;
				bc_n  = '0;
				tot_n = '0;
			end
			bitpk_pkg::ACT_WRITE: begin
				if (ok) begin
					wc_n  = nwc;
					bc_n  = split.r;
					tot_n = nwc + {{(CW-1){1'b0}}, (split.r != 4'd0)};
				end
			end
			bitpk_pkg::ACT_READ_BITS: begin
				if (ok) begin
					wc_n   = nwc;
					bc_n   = split.r;
					rdat_n = r_out;
				end
			end
			bitpk_pkg::ACT_REWIND: begin
				if (ok) begin
					wc_n = tw_q;
					bc_n = tb;
				end
			end
			bitpk_pkg::ACT_APPEND: begin
				if (ok) begin
					tot_n = total_q + {{(CW-1){1'b0}}, 1'b1};
				end
			end
			bitpk_pkg::ACT_READ_WORD: begin
				if (ok) begin
					rdat_n = {{(DW-WB){1'b0}}, coll_q[SB-1 -: WB]};
				end
			end
			default: begin
			end
		endcase
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q       <= n_in;
			wdat_q    <= {la_dat, {(SB-DW){1'b0}}} >> bc_q;
			wmsk_q    <= {la_msk, {(SB-DW){1'b0}}} >> bc_q;
			pos_q     <= bit_position;
			tw_q      <= pos_prod[17:11];
			rew_err_q <= ({1'b0, bit_position} > glob);
			wval_q    <= word_value;
			widx_q    <= word_index;
		end
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q  <= valid_q[rd_addr];
		end
		if (cmd.collect) begin
			for (int i = 0; i < bitpk_pkg::SPAN_WORDS; i++) begin
				if (cmd.k == 3'(i)) begin
					coll_q[SB-1-i*WB -: WB] <= rd_eff;
				end
			end
		end
		if (cmd.commit) begin
			rdat_q <= rdat_n;
			used_q <= tot_n;
			code_q <= err_q;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= bitpk_pkg::ACT_CLEAR;
			err_q       <= bitpk_pkg::ERR_OK;
			wc_q        <= '0;
			bc_q        <= '0;
			total_q     <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				act_q <= action;
				err_q <= bitpk_pkg::ERR_OK;
			end else if (cmd.err_en) begin
				err_q <= cmd.err_code;
			end
			if (cmd.commit) begin
				wc_q    <= wc_n;
				bc_q    <= bc_n;
				total_q <= tot_n;
			end
			if (cmd.commit && act_q == bitpk_pkg::ACT_CLEAR) begin
				valid_q <= '0;
			end else begin
				if (cmd.range_clr) begin
					valid_q <= valid_q & ~clr_vec;
				end
				if (cmd.wr_en) begin
					valid_q[wr_addr] <= 1'b1;
				end
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_free) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_data  = rdat_q;
	assign used_words = used_q;
	assign error_code = code_q;

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> rsp_free)
		else $error("result committed while the result register is occupied");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> wr_addr_full < STORE_END)
		else $error("store write outside the word store");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && act_q == bitpk_pkg::ACT_CLEAR
		|=> total_q == '0 && wc_q == '0 && bc_q == '0 && valid_q == '0)
		else $error("clear left state behind");

	a_fault_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && err_q != bitpk_pkg::ERR_OK
		|=> wc_q == $past(wc_q) && bc_q == $past(bc_q) && total_q == $past(total_q))
		else $error("refused item changed the cursor or word count");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q >= STORE_END |-> wc_q == STORE_END && bc_q == '0)
		else $error("cursor beyond the end of the store");
`endif

endmodule

[src/ten_bit_word_bit_packer.sv]
// Top level of the ten-bit word bit packer: request and response channels,
// controller and datapath. Depends on bitpk_pkg, bitpk_ctrl and bitpk_datapath.
//
// The block keeps a store of 64 ten-bit words and one bit cursor into it, and
// answers every request item with exactly one response item. Bits are written
// most significant first by ORing them in at the cursor and are read back the
// same way; a rewind moves the cursor back and clears the bits it passes over;
// whole words can be appended at the word count and read back by index. A
// faulty request changes nothing and is answered with an error code. Requests
// are handled one at a time: the request side is stalled from acceptance until
// the response is placed in the output register, which then frees the
// request side even while the response waits on a stalled consumer. The
// store is a single-port word memory with a registered read, and the span
// bit operations walk it one word at a time: each word is read and then
// checked, and a write then writes every span word back in a second pass. A
// span touches at most five words. A write of bits stops early on a fault,
// and every response waits while the output register is still occupied. The
// word store needs no clearing pass: a valid flag per word, reset at once,
// makes every unwritten word read as zero.
module ten_bit_word_bit_packer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [2:0]                       action,
	input  logic [bitpk_pkg::DATA_W-1:0]     bit_data,
	input  logic [5:0]                       bit_count,
	input  logic [9:0]                       bit_position,
	input  logic [bitpk_pkg::WORD_BITS-1:0]  word_value,
	input  logic [5:0]                       word_index,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [bitpk_pkg::DATA_W-1:0]     read_data,
	output logic [bitpk_pkg::CNT_W-1:0]      used_words,
	output logic [1:0]                       error_code
);

	// Commands flow from the controller to the datapath, status flows back.
	bitpk_pkg::cmd_t    cmd;
	bitpk_pkg::status_t st;

	// The controller sequences each item: dispatch on the action, walk the
	// span words for bit reads and writes, and commit once the output
	// register can take the response.
	bitpk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the cursor, word count, word store and the
	// response register that parts the two channels.
	bitpk_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (action),
		.bit_data     (bit_data),
		.bit_count    (bit_count),
		.bit_position (bit_position),
		.word_value   (word_value),
		.word_index   (word_index),
		.rsp_stall    (rsp_stall),
		.cmd          (cmd),
		.st           (st),
		.rsp_valid    (rsp_valid),
		.read_data    (read_data),
		.used_words   (used_words),
		.error_code   (error_code)
	);

endmodule

[tb/sv/bitpk_checker.sv]
// Response checker for the ten-bit word bit packer: it watches both channels,
// predicts each response from its own copy of the store and cursor, and counts
// mismatches. Depends on bitpk_pkg for the action and error codes.
module bitpk_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_stall,
	input  logic [2:0]                       action,
	input  logic [bitpk_pkg::DATA_W-1:0]     bit_data,
	input  logic [5:0]                       bit_count,
	input  logic [9:0]                       bit_position,
	input  logic [bitpk_pkg::WORD_BITS-1:0]  word_value,
	input  logic [5:0]                       word_index,
	input  logic                             rsp_valid,
	input  logic                             rsp_stall,
	input  logic [bitpk_pkg::DATA_W-1:0]     read_data,
	input  logic [bitpk_pkg::CNT_W-1:0]      used_words,
	input  logic [1:0]                       error_code,
	output int                               fail_count,
	output int                               pending
);
	import bitpk_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]  used_words;
		logic [1:0]        error_code;
	} packer_rsp_t;

	logic [WORD_BITS-1:0] words [STORE_WORDS];
	int unsigned cur_w;
	int unsigned cur_b;
	int unsigned total;
	packer_rsp_t owed_rsp [$];
	int mismatches = 0;

	assign fail_count = mismatches;

	function automatic void clear_store();
		for (int i = 0; i < STORE_WORDS; i++)
			words[i] = '0;
		cur_w = 0;
		cur_b = 0;
		total = 0;
	endfunction

	// The whole span is checked before any bit is set, so a fault leaves the
	// store and cursor as they were.
	function automatic logic [1:0] write_bits(logic [DATA_W-1:0] data, int unsigned n);
		int unsigned w;
		int unsigned b;
		w = cur_w;
		b = cur_b;
		for (int i = 0; i < n; i++) begin
			if (w >= STORE_WORDS)
				return ERR_OVERRUN;
			if (words[w][WORD_BITS-1-b])
				return ERR_BIT_SET;
			b++;
			if (b == WORD_BITS) begin
				b = 0;
				w++;
			end
		end
		for (int i = n; i > 0; i--) begin
			if (data[i-1])
				words[cur_w][WORD_BITS-1-cur_b] = 1'b1;
			cur_b++;
			if (cur_b == WORD_BITS) begin
				cur_b = 0;
				cur_w++;
			end
		end
		total = cur_w + ((cur_b != 0) ? 1 : 0);
		return ERR_OK;
	endfunction

	function automatic logic [1:0] read_bits(int unsigned n, output logic [DATA_W-1:0] bits);
		int unsigned w;
		int unsigned b;
		w = cur_w;
		b = cur_b;
		bits = '0;
		for (int i = 0; i < n; i++) begin
			if (w >= STORE_WORDS) begin
				bits = '0;
				return ERR_OVERRUN;
			end
			bits = {bits[DATA_W-2:0], words[w][WORD_BITS-1-b]};
			b++;
			if (b == WORD_BITS) begin
				b = 0;
				w++;
			end
		end
		cur_w = w;
		cur_b = b;
		return ERR_OK;
	endfunction

	// Clears from the target position up to the cursor; the word holding the
	// cursor is only cleared when the cursor sits inside it.
	function automatic logic [1:0] rewind_to(logic [9:0] pos);
		int unsigned tw;
		int unsigned tb;
		logic [31:0] keep;
		tw = pos / WORD_BITS;
		tb = pos % WORD_BITS;
		if (int'(pos) > int'(cur_w * WORD_BITS + cur_b))
			return ERR_REWIND;
		for (int unsigned w = tw + 1; w <= cur_w; w++) begin
			if (w >= STORE_WORDS)
				break;
			if (w < cur_w || cur_b > 0)
				words[w] = '0;
		end
		if (tw < STORE_WORDS) begin
			keep = 32'hFFFF << (WORD_BITS - tb);
			words[tw] = words[tw] & keep[WORD_BITS-1:0];
		end
		cur_w = tw;
		cur_b = tb;
		return ERR_OK;
	endfunction

	function automatic packer_rsp_t apply_request(logic [2:0] act, logic [DATA_W-1:0] data,
			logic [5:0] cnt, logic [9:0] pos, logic [WORD_BITS-1:0] val, logic [5:0] idx);
		packer_rsp_t r;
		int unsigned n;
		r = '0;
		n = (cnt > 6'd32) ? 32 : int'(cnt);
		case (act)
			ACT_CLEAR: begin
				clear_store();
			end
			ACT_WRITE: begin
				r.error_code = write_bits(data, n);
			end
			ACT_READ_BITS: begin
				r.error_code = read_bits(n, r.read_data);
			end
			ACT_REWIND: begin
				r.error_code = rewind_to(pos);
			end
			ACT_APPEND: begin
				if (total >= STORE_WORDS) begin
					r.error_code = ERR_OVERRUN;
				end else begin
					words[total] = val;
					total++;
				end
			end
			ACT_READ_WORD: begin
				if (idx >= STORE_WORDS)
					r.error_code = ERR_OVERRUN;
				else
					r.read_data = DATA_W'(words[idx]);
			end
			default: begin
			end
		endcase
		r.used_words = CNT_W'(total);
		return r;
	endfunction

	task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		// Only the first mismatches are printed to keep the log short.
		if (mismatches < 40)
			$display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		packer_rsp_t want;
		if (!arst_n) begin
			clear_store();
			owed_rsp.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					report("response with none expected", read_data, '0);
				end else begin
					want = owed_rsp.pop_front();
					if (read_data !== want.read_data)
						report("read_data", read_data, want.read_data);
					if (used_words !== want.used_words)
						report("used_words", DATA_W'(used_words), DATA_W'(want.used_words));
					if (error_code !== want.error_code)
						report("error_code", DATA_W'(error_code), DATA_W'(want.error_code));
				end
			end
			if (req_valid && !req_stall)
				owed_rsp.push_back(apply_request(action, bit_data, bit_count,
					bit_position, word_value, word_index));
			pending <= owed_rsp.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
// Top of the bit packer testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on bitpk_pkg, bitpk_checker and the
// ten_bit_word_bit_packer block.
module tb_top;
	import bitpk_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int ITEM_GOAL    = 1750;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20000;
	localparam int SETTLE       = 32;
	localparam int TOTAL_BITS   = STORE_WORDS * WORD_BITS;

	// Action codes the block does not use; they must change nothing.
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	// Every input of the block has a known value from time zero.
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 req_valid    = 1'b0;
	logic                 req_stall;
	logic [2:0]           action       = ACT_CLEAR;
	logic [DATA_W-1:0]    bit_data     = '0;
	logic [5:0]           bit_count    = '0;
	logic [9:0]           bit_position = '0;
	logic [WORD_BITS-1:0] word_value   = '0;
	logic [5:0]           word_index   = '0;
	logic                 rsp_valid;
	logic                 rsp_stall    = 1'b0;
	logic [DATA_W-1:0]    read_data;
	logic [CNT_W-1:0]     used_words;
	logic [1:0]           error_code;

	int fail_count;
	int pending;

	// Stimulus state: a rough guess of the bit cursor used only to aim rewinds,
	// the number of counted items sent, the calm flag that switches off all
	// idling for a session, and the count of long receiver hold-offs asked for.
	int est_bits      = 0;
	int items_sent    = 0;
	bit calm          = 1'b0;
	int squeeze_asked = 0;

	ten_bit_word_bit_packer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.bit_data     (bit_data),
		.bit_count    (bit_count),
		.bit_position (bit_position),
		.word_value   (word_value),
		.word_index   (word_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.read_data    (read_data),
		.used_words   (used_words),
		.error_code   (error_code)
	);

	bitpk_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.bit_data     (bit_data),
		.bit_count    (bit_count),
		.bit_position (bit_position),
		.word_value   (word_value),
		.word_index   (word_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.read_data    (read_data),
		.used_words   (used_words),
		.error_code   (error_code),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on the run, several times the slowest correct run.
	initial begin
		#(4 * LIMIT_CYCLES);
		$display("FAILURE");
		$finish;
	end

	// Length of an idle stretch: mostly none or short, now and then long.
	// In a calm session there is no idling at all.
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (calm || p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one item after a random gap and returns at the edge that accepts
	// it. Valid is only lowered when a gap follows, so that a valid that stays
	// high for back-to-back items never gets two assignments in one step.
	// The payload is held until acceptance.
	task automatic send_item(input logic [2:0] act, input logic [DATA_W-1:0] data,
			input logic [5:0] cnt, input logic [9:0] pos,
			input logic [WORD_BITS-1:0] val, input logic [5:0] idx);
		int unsigned gap;
		int n;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		action       <= act;
		bit_data     <= data;
		bit_count    <= cnt;
		bit_position <= pos;
		word_value   <= val;
		word_index   <= idx;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// Keep the cursor guess roughly in step; faults make it drift, which
		// only shifts the mix of rewind outcomes.
		n = (cnt > 6'd32) ? 32 : int'(cnt);
		case (act)
			ACT_CLEAR: begin
				est_bits = 0;
			end
			ACT_WRITE, ACT_READ_BITS: begin
				if (est_bits + n <= TOTAL_BITS)
					est_bits += n;
			end
			ACT_REWIND: begin
				if (int'(pos) <= est_bits)
					est_bits = int'(pos);
			end
			default: begin
			end
		endcase
		if (act <= ACT_READ_WORD)
			items_sent++;
	endtask

	// Response side: random stalls of mixed length, free stretches between
	// them, and a long hold-off whenever the stimulus asks for one. During a
	// hold-off the sender keeps offering, so the block fills its output
	// register and then stalls its input.
	initial begin : receiver
		int unsigned run;
		int held;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (held < squeeze_asked) begin
				held++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				run = pick_gap();
				rsp_stall <= 1'b1;
				repeat (run + 1) @(posedge clk);
			end else begin
				run = calm ? 8 : pick_gap();
				rsp_stall <= 1'b0;
				repeat (run + 1) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int kind;
		int len;
		int n;
		int p;
		int sessions;
		int t_wr;
		int t_rd;
		int t_rw;
		int t_ap;
		int t_rwd;
		int lo;
		logic [5:0] cnt;
		logic [9:0] pos;
		logic [WORD_BITS-1:0] val;

		sessions = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The store reads as zero after reset, a zero-length
		// write still sets the word count, and a full-width write of ones is
		// followed by one of zeros.
		send_item(ACT_READ_WORD, '0, 6'd0, 10'd0, '0, 6'd0);
		send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd0, 10'd0, '0, 6'd0);
		send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd32, 10'd0, '0, 6'd0);
		send_item(ACT_WRITE, 32'h0, 6'd32, 10'd0, '0, 6'd0);
		// Rewinds past the cursor are refused; a rewind onto the cursor
		// clears nothing that was written.
		send_item(ACT_REWIND, '0, 6'd0, 10'd1023, '0, 6'd0);
		send_item(ACT_REWIND, '0, 6'd0, 10'd65, '0, 6'd0);
		send_item(ACT_REWIND, '0, 6'd0, 10'd64, '0, 6'd0);
		send_item(ACT_REWIND, '0, 6'd0, 10'd5, '0, 6'd0);
		// A count above 32 reads 32 bits.
		send_item(ACT_READ_BITS, '0, 6'd63, 10'd0, '0, 6'd0);
		send_item(ACT_APPEND, '0, 6'd0, 10'd0, 10'h3FF, 6'd0);
		send_item(ACT_APPEND, '0, 6'd0, 10'd0, 10'h000, 6'd0);
		send_item(ACT_READ_WORD, '0, 6'd0, 10'd0, '0, 6'd63);
		// Walk the cursor onto the appended word of ones, try to set a bit already
		// set, read the word back, then write the next word and read it by index.
		send_item(ACT_READ_BITS, '0, 6'd32, 10'd0, '0, 6'd0);
		send_item(ACT_READ_BITS, '0, 6'd1, 10'd0, '0, 6'd0);
		send_item(ACT_WRITE, 32'h1, 6'd1, 10'd0, '0, 6'd0);
		send_item(ACT_READ_BITS, '0, 6'd10, 10'd0, '0, 6'd0);
		send_item(ACT_WRITE, 32'h2AA, 6'd10, 10'd0, '0, 6'd0);
		send_item(ACT_READ_WORD, '0, 6'd0, 10'd0, '0, 6'd8);
		// The unused action codes change nothing.
		send_item(ACT_SPARE_LO, 32'hFFFF_FFFF, 6'd63, 10'd1023, 10'h3FF, 6'd63);
		send_item(ACT_SPARE_HI, 32'hFFFF_FFFF, 6'd63, 10'd1023, 10'h3FF, 6'd63);
		send_item(ACT_REWIND, '0, 6'd0, 10'd0, '0, 6'd0);
		send_item(ACT_CLEAR, '0, 6'd0, 10'd0, '0, 6'd0);
		send_item(ACT_READ_BITS, '0, 6'd0, 10'd0, '0, 6'd0);

		// Random part in sessions that each start from a cleared store.
		// Mixed sessions spread over all actions, fill sessions write toward
		// the end of the store to reach overruns, and append sessions build
		// up whole words and read them back.
		while (items_sent < ITEM_GOAL) begin
			kind = $urandom_range(0, 9);
			calm = ($urandom_range(0, 4) == 0);
			if (sessions == 1 || kind == 0)
				squeeze_asked++;
			sessions++;
			if (kind < 4) begin
				t_wr = 30; t_rd = 45; t_rw = 60; t_ap = 78; t_rwd = 93;
				len = $urandom_range(30, 90);
				lo = 0;
			end else if (kind < 7) begin
				t_wr = 60; t_rd = 70; t_rw = 82; t_ap = 88; t_rwd = 96;
				len = $urandom_range(40, 80);
				lo = 16;
			end else begin
				t_wr = 10; t_rd = 25; t_rw = 35; t_ap = 80; t_rwd = 95;
				len = $urandom_range(80, 160);
				lo = 0;
			end
			send_item(ACT_CLEAR, $urandom, 6'($urandom), 10'($urandom), 10'($urandom),
				6'($urandom));
			for (n = 0; n < len; n++) begin
				p = $urandom_range(0, 99);
				cnt = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(33, 63))
					: 6'($urandom_range(lo, 32));
				if (p < t_wr) begin
					send_item(ACT_WRITE, $urandom, cnt, 10'($urandom), 10'($urandom),
						6'($urandom));
				end else if (p < t_rd) begin
					send_item(ACT_READ_BITS, $urandom, cnt, 10'($urandom), 10'($urandom),
						6'($urandom));
				end else if (p < t_rw) begin
					// Mostly back to somewhere inside the written span, sometimes
					// exactly onto the cursor, sometimes anywhere at all.
					case ($urandom_range(0, 7))
						0: pos = 10'($urandom_range(0, 1023));
						1: pos = 10'(est_bits);
						default: pos = 10'($urandom_range(0, est_bits));
					endcase
					send_item(ACT_REWIND, $urandom, 6'($urandom), pos, 10'($urandom),
						6'($urandom));
				end else if (p < t_ap) begin
					val = ($urandom_range(0, 3) == 0) ? {WORD_BITS{$urandom_range(0, 1) == 1}}
						: 10'($urandom);
					send_item(ACT_APPEND, $urandom, 6'($urandom), 10'($urandom), val,
						6'($urandom));
				end else if (p < t_rwd) begin
					send_item(ACT_READ_WORD, $urandom, 6'($urandom), 10'($urandom),
						10'($urandom), 6'($urandom_range(0, 63)));
				end else begin
					send_item(3'(ACT_SPARE_LO + $urandom_range(0, 1)), $urandom,
						6'($urandom), 10'($urandom), 10'($urandom), 6'($urandom));
				end
			end
		end
		req_valid <= 1'b0;
		calm = 1'b0;

		// Let every owed response arrive, then wait out the SETTLE stretch so that a
		// stray extra response would still be seen. The checker's count is registered,
		// so it includes the last item only once the accepting edge has passed.
		@(posedge clk);
		for (n = 0; n < DRAIN_CYCLES && pending != 0; n++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[ten_bit_word_bit_packer.f]
src/bitpk_pkg.sv
src/bitpk_ctrl.sv
src/bitpk_datapath.sv
src/ten_bit_word_bit_packer.sv
tb/sv/bitpk_checker.sv
tb/sv/tb_top.sv
